[rtl/tlssni_pkg.sv]
// Package for the ClientHello server-name extractor.
// Holds the transfer payload types, parse phase codes and status codes.
// No dependencies.
`default_nettype none

package tlssni_pkg;

    // Fixed header: type, 3-byte length, version, 32-byte random
    localparam int HDR_BYTES = 38;
    localparam logic [15:0] HDR_LAST = 16'(HDR_BYTES - 1);

    localparam logic [1:0] ST_NAME_BYTE = 2'd0;
    localparam logic [1:0] ST_NO_NAME   = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] name_byte;
        logic [1:0] status;
        logic       is_last;
    } out_item_t;

    typedef enum logic [14:0] {
        PH_HDR       = 15'h0001,
        PH_SID_LEN   = 15'h0002,
        PH_SID_SKIP  = 15'h0004,
        PH_CS_HI     = 15'h0008,
        PH_CS_LO     = 15'h0010,
        PH_CS_SKIP   = 15'h0020,
        PH_COMP_LEN  = 15'h0040,
        PH_COMP_SKIP = 15'h0080,
        PH_EXTS_HI   = 15'h0100,
        PH_EXTS_LO   = 15'h0200,
        PH_EXT_HDR   = 15'h0400,
        PH_EXT_BODY  = 15'h0800,
        PH_SNI_HDR   = 15'h1000,
        PH_NAME      = 15'h2000,
        PH_DONE      = 15'h4000
    } phase_t;

endpackage

`default_nettype wire

[rtl/tlssni_parse.sv]
// Parse state and per-byte next-state logic for the server-name extractor.
// Holds the extension type register. Depends on tlssni_pkg.
`default_nettype none

module tlssni_parse
    import tlssni_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_valid,
    input  wire logic [15:0] cfg_data,
    input  wire logic      accept,
    input  wire in_item_t  item,
    output logic           res_valid,
    output out_item_t      res_item
);

    phase_t      phase_reg, phase_next;
    logic [15:0] fbl_reg, fbl_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] exts_left_reg, exts_left_next;
    logic [15:0] ext_type_reg, ext_type_next;
    logic [15:0] ext_left_reg, ext_left_next;
    logic        found_reg, found_next;
    logic [15:0] sni_type_reg;

    logic [15:0] word;
    logic [15:0] exts_dec;
    logic [15:0] body_dec;
    logic [15:0] name_len;
    logic [15:0] fbl_dec;
    logic        fbl_end;
    logic [7:0]  b;
    logic        emit;
    logic [7:0]  nb;
    logic [1:0]  st;
    logic        last;

    assign b        = item.data_byte;
    assign word     = {len_hi_reg, b};
    assign exts_dec = (exts_left_reg != '0) ? exts_left_reg - 16'd1 : '0;
    assign body_dec = (ext_left_reg != '0) ? ext_left_reg - 16'd1 : '0;
    assign name_len = (word > body_dec) ? body_dec : word;
    assign fbl_end  = (fbl_reg <= 16'd1);
    assign fbl_dec  = fbl_reg - 16'd1;

    always_comb begin
        phase_next     = phase_reg;
        fbl_next       = fbl_reg;
        len_hi_next    = len_hi_reg;
        exts_left_next = exts_left_reg;
        ext_type_next  = ext_type_reg;
        ext_left_next  = ext_left_reg;
        found_next     = found_reg;
        emit           = 1'b0;
        nb             = 8'd0;
        st             = ST_NAME_BYTE;
        last           = 1'b0;

        unique case (phase_reg)
            PH_HDR: begin
                if (fbl_reg >= HDR_LAST) begin
                    fbl_next   = '0;
                    phase_next = PH_SID_LEN;
                end else begin
                    fbl_next = fbl_reg + 16'd1;
                end
            end
            PH_SID_LEN: begin
                fbl_next   = {8'd0, b};
                phase_next = (b != 8'd0) ? PH_SID_SKIP : PH_CS_HI;
            end
            PH_SID_SKIP: begin
                fbl_next = fbl_end ? '0 : fbl_dec;
                if (fbl_end) phase_next = PH_CS_HI;
            end
            PH_CS_HI: begin
                len_hi_next = b;
                phase_next  = PH_CS_LO;
            end
            PH_CS_LO: begin
                fbl_next   = word;
                phase_next = (word != '0) ? PH_CS_SKIP : PH_COMP_LEN;
            end
            PH_CS_SKIP: begin
                fbl_next = fbl_end ? '0 : fbl_dec;
                if (fbl_end) phase_next = PH_COMP_LEN;
            end
            PH_COMP_LEN: begin
                fbl_next   = {8'd0, b};
                phase_next = (b != 8'd0) ? PH_COMP_SKIP : PH_EXTS_HI;
            end
            PH_COMP_SKIP: begin
                fbl_next = fbl_end ? '0 : fbl_dec;
                if (fbl_end) phase_next = PH_EXTS_HI;
            end
            PH_EXTS_HI: begin
                len_hi_next = b;
                phase_next  = PH_EXTS_LO;
            end
            PH_EXTS_LO: begin
                exts_left_next = word;
                fbl_next       = '0;
                phase_next     = (word == '0) ? PH_DONE : PH_EXT_HDR;
            end
            PH_EXT_HDR: begin
                exts_left_next = exts_dec;
                if (fbl_reg == 16'd0 || fbl_reg == 16'd2) begin
                    len_hi_next = b;
                    fbl_next    = fbl_reg + 16'd1;
                end else if (fbl_reg == 16'd1) begin
                    ext_type_next = word;
                    fbl_next      = fbl_reg + 16'd1;
                end else begin
                    ext_left_next = word;
                    fbl_next      = '0;
                    if (word == '0) begin
                        // empty extension is skipped, even a matching one
                        phase_next = (exts_dec == '0) ? PH_DONE : PH_EXT_HDR;
                    end else if (ext_type_reg == sni_type_reg && !found_reg) begin
                        phase_next = PH_SNI_HDR;
                    end else begin
                        phase_next = PH_EXT_BODY;
                    end
                end
            end
            PH_EXT_BODY: begin
                exts_left_next = exts_dec;
                ext_left_next  = body_dec;
                if (body_dec == '0) begin
                    fbl_next   = '0;
                    phase_next = (exts_dec == '0) ? PH_DONE : PH_EXT_HDR;
                end
            end
            PH_SNI_HDR: begin
                // list length (2), name type (1), name length (2)
                exts_left_next = exts_dec;
                ext_left_next  = body_dec;
                if (fbl_reg == 16'd3) len_hi_next = b;
                if (body_dec == '0) begin
                    fbl_next   = '0;
                    phase_next = (exts_dec == '0) ? PH_DONE : PH_EXT_HDR;
                end else if (fbl_reg >= 16'd4) begin
                    // name is cut at the end of its extension
                    fbl_next   = name_len;
                    phase_next = (name_len != '0) ? PH_NAME : PH_EXT_BODY;
                end else begin
                    fbl_next = fbl_reg + 16'd1;
                end
            end
            PH_NAME: begin
                exts_left_next = exts_dec;
                ext_left_next  = body_dec;
                emit           = 1'b1;
                nb             = b;
                if (fbl_end) begin
                    fbl_next   = '0;
                    found_next = 1'b1;
                    last       = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    fbl_next = fbl_dec;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (item.end_of_message) begin
            if (phase_next != PH_DONE) begin
                emit = 1'b1;
                nb   = 8'd0;
                st   = ST_TRUNCATED;
                last = 1'b1;
            end else if (!found_next) begin
                emit = 1'b1;
                nb   = 8'd0;
                st   = ST_NO_NAME;
                last = 1'b1;
            end
            phase_next     = PH_HDR;
            fbl_next       = '0;
            len_hi_next    = '0;
            exts_left_next = '0;
            ext_type_next  = '0;
            ext_left_next  = '0;
            found_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HDR;
            fbl_reg       <= '0;
            len_hi_reg    <= '0;
            exts_left_reg <= '0;
            ext_type_reg  <= '0;
            ext_left_reg  <= '0;
            found_reg     <= 1'b0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            fbl_reg       <= fbl_next;
            len_hi_reg    <= len_hi_next;
            exts_left_reg <= exts_left_next;
            ext_type_reg  <= ext_type_next;
            ext_left_reg  <= ext_left_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sni_type_reg <= '0;
        end else if (cfg_valid) begin
            sni_type_reg <= cfg_data;
        end
    end

    assign res_valid          = accept && emit;
    assign res_item.name_byte = nb;
    assign res_item.status    = st;
    assign res_item.is_last   = last;

endmodule

`default_nettype wire

[rtl/tlssni_out_reg.sv]
// Result register for the server-name extractor: holds one result until
// the downstream transfer completes. Depends on tlssni_pkg.
`default_nettype none

module tlssni_out_reg
    import tlssni_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push_valid,
    input  wire out_item_t push_item,
    output logic           free,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic      valid_reg, valid_next;
    out_item_t data_reg;

    // slot frees up in the same cycle the held result is taken
    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (free) valid_next = push_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && push_valid) data_reg <= push_item;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

[rtl/tls_client_hello_sni_extract.sv]
// A result is registered and appears on m_valid in the cycle after the byte that causes it.
// Throughput: one byte per cycle while s_ready is high; each byte updates the parse state in one pass.
// Input stalls only while the result register holds a result not yet taken.
// Reset (aresetn low, synchronous): parse state to message start, no result
// held, server-name type register to 0. Configuration writes always accepted.
`default_nettype none

module tls_client_hello_sni_extract
    import tlssni_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data
);

    logic      accept;
    logic      res_valid;
    out_item_t res_item;
    logic      slot_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = slot_free;
    assign accept    = s_valid && slot_free;

    tlssni_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (s_data),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    tlssni_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (res_valid),
        .push_item  (res_item),
        .free       (slot_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

[rtl/tlssni_checker.sv]
// Port-level checks for the server-name extractor, bound to the top level.
// Depends on tlssni_pkg.
`default_nettype none

module tlssni_checker
    import tlssni_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // a status result always closes the message
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_NAME_BYTE |-> m_data.is_last)
        else $error("status result without is_last");

    // status results carry a zero byte
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_NAME_BYTE |-> m_data.name_byte == 8'd0)
        else $error("status result with nonzero name byte");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    // an empty result register never holds off the input
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !m_valid |-> s_ready)
        else $error("input stalled with no result held");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

endmodule

bind tls_client_hello_sni_extract tlssni_checker u_tlssni_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
